// ===== hw/rtl/nfcsel_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcsel_pkg
// Types, constants and the control store of the type A activation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcsel_pkg;

  // Input word: one event from the front end
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  rx_len;
    logic [39:0] rx_data;
  } in_word_t;

  // Output word: one transmit, wait, UID byte or finish report
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tx_command;
    logic [7:0]  select_code;
    logic [39:0] tx_payload;
    logic        anticoll_enable;
    logic [7:0]  time_ms;
    logic [7:0]  uid_byte;
    logic [1:0]  status;
    logic [15:0] atqa;
    logic [7:0]  sak;
    logic [3:0]  uid_length;
    logic        last;
  } out_word_t;

  // Event codes
  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_FRAME   = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ANTICOLL_ATTEMPTS   = 3'd0,
    CFG_RETRY_DELAY_MS      = 3'd1,
    CFG_REACTIVATE_DELAY_MS = 3'd2,
    CFG_ATQA_TIMEOUT_MS     = 3'd3,
    CFG_ANTICOLL_TIMEOUT_MS = 3'd4,
    CFG_SELECT_TIMEOUT_MS   = 3'd5
  } cfg_reg_e;

  // Output word kinds
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_WAIT = 2'd1,
    KIND_UID  = 2'd2,
    KIND_FIN  = 2'd3
  } kind_e;

  // Transmit commands
  typedef enum logic [1:0] {
    TX_REQA     = 2'd0,
    TX_WUPA     = 2'd1,
    TX_ANTICOLL = 2'd2,
    TX_SELECT   = 2'd3
  } tx_cmd_e;

  // Finish status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CARD   = 2'd1,
    ST_COLLISION = 2'd2,
    ST_PROTOCOL  = 2'd3
  } status_e;

  // Protocol phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_REQA = 5'b00010,
    PH_WUPA = 5'b00100,
    PH_ANTI = 5'b01000,
    PH_SEL  = 5'b10000
  } phase_e;

  // Source of the time field
  typedef enum logic [2:0] {
    TS_NONE     = 3'd0,
    TS_ATQA     = 3'd1,
    TS_ANTICOLL = 3'd2,
    TS_SELECT   = 3'd3,
    TS_RETRY    = 3'd4,
    TS_REACT    = 3'd5
  } time_sel_e;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_START       = 4'd1,
    ACT_ATQA        = 4'd2,
    ACT_UID_PART    = 4'd3,
    ACT_INC_ATTEMPT = 4'd4,
    ACT_SEL_INIT    = 4'd5,
    ACT_APPEND      = 4'd6,
    ACT_IDX_CLR     = 4'd7,
    ACT_IDX_INC     = 4'd8,
    ACT_NEXT_LEVEL  = 4'd9
  } act_e;

  // Sequencing
  typedef enum logic [1:0] {
    SEQ_NEXT   = 2'd0,
    SEQ_JUMP   = 2'd1,
    SEQ_BRANCH = 2'd2,
    SEQ_END    = 2'd3
  } seq_e;

  // Branch conditions
  typedef enum logic [1:0] {
    CND_RETRY_MORE  = 2'd0,
    CND_APPEND_MORE = 2'd1,
    CND_NEXT_LEVEL  = 2'd2,
    CND_UID_MORE    = 2'd3
  } cond_e;

  typedef logic [4:0] upc_t;

  // Control word
  typedef struct packed {
    logic      emit;
    kind_e     kind;
    tx_cmd_e   cmd;
    logic      code_en;
    logic      payload_en;
    logic      ac;
    time_sel_e tsel;
    status_e   st;
    act_e      act;
    logic      ph_we;
    phase_e    ph;
    seq_e      seq;
    cond_e     cond;
    upc_t      target;
  } ucode_t;

  // Protocol constants
  localparam logic [7:0] SelCodeBase    = 8'h93;
  localparam logic [7:0] CascadeTag     = 8'h88;
  localparam int unsigned SakCascadeBit = 2;
  localparam logic [3:0] UidMaxBytes    = 4'd12;
  localparam int unsigned UidDepth      = 12;

  // Entry points of the program
  localparam upc_t UA_START      = 5'd0;
  localparam upc_t UA_ATQA_OK    = 5'd1;
  localparam upc_t UA_SEND_ANTI  = 5'd2;
  localparam upc_t UA_REQA_FAIL  = 5'd3;
  localparam upc_t UA_FIN_NOCARD = 5'd5;
  localparam upc_t UA_ANTI_OK    = 5'd6;
  localparam upc_t UA_ANTI_FAIL  = 5'd7;
  localparam upc_t UA_SEL_OK     = 5'd10;
  localparam upc_t UA_APPEND     = 5'd11;
  localparam upc_t UA_UID_EMIT   = 5'd13;
  localparam upc_t UA_NEXT_LEVEL = 5'd15;
  localparam upc_t UA_FIN_PROTO  = 5'd16;

  // Control store
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    w = '0;
    w.kind = KIND_TX;
    w.cmd  = TX_REQA;
    w.tsel = TS_NONE;
    w.st   = ST_OK;
    w.act  = ACT_NONE;
    w.ph   = PH_IDLE;
    w.seq  = SEQ_END;
    w.cond = CND_RETRY_MORE;
    unique case (addr)
      // start: clear run state, send REQA
      5'd0: begin
        w.act = ACT_START;
        w.emit = 1'b1; w.kind = KIND_TX; w.cmd = TX_REQA; w.tsel = TS_ATQA;
        w.ph_we = 1'b1; w.ph = PH_REQA; w.seq = SEQ_END;
      end
      // ATQA seen
      5'd1: begin
        w.act = ACT_ATQA; w.seq = SEQ_JUMP; w.target = UA_SEND_ANTI;
      end
      // send anticollision frame
      5'd2: begin
        w.emit = 1'b1; w.kind = KIND_TX; w.cmd = TX_ANTICOLL; w.code_en = 1'b1;
        w.ac = 1'b1; w.tsel = TS_ANTICOLL;
        w.ph_we = 1'b1; w.ph = PH_ANTI; w.seq = SEQ_END;
      end
      // REQA failed: wait, then WUPA
      5'd3: begin
        w.emit = 1'b1; w.kind = KIND_WAIT; w.tsel = TS_REACT; w.seq = SEQ_NEXT;
      end
      5'd4: begin
        w.emit = 1'b1; w.kind = KIND_TX; w.cmd = TX_WUPA; w.tsel = TS_ATQA;
        w.ph_we = 1'b1; w.ph = PH_WUPA; w.seq = SEQ_END;
      end
      // WUPA failed
      5'd5: begin
        w.emit = 1'b1; w.kind = KIND_FIN; w.st = ST_NO_CARD;
        w.ph_we = 1'b1; w.ph = PH_IDLE; w.seq = SEQ_END;
      end
      // UID part received: SELECT it
      5'd6: begin
        w.act = ACT_UID_PART;
        w.emit = 1'b1; w.kind = KIND_TX; w.cmd = TX_SELECT; w.code_en = 1'b1;
        w.payload_en = 1'b1; w.tsel = TS_SELECT;
        w.ph_we = 1'b1; w.ph = PH_SEL; w.seq = SEQ_END;
      end
      // failed try: wait, count it, retry or give up
      5'd7: begin
        w.emit = 1'b1; w.kind = KIND_WAIT; w.tsel = TS_RETRY;
        w.act = ACT_INC_ATTEMPT; w.seq = SEQ_NEXT;
      end
      5'd8: begin
        w.seq = SEQ_BRANCH; w.cond = CND_RETRY_MORE; w.target = UA_SEND_ANTI;
      end
      5'd9: begin
        w.emit = 1'b1; w.kind = KIND_FIN; w.st = ST_COLLISION;
        w.ph_we = 1'b1; w.ph = PH_IDLE; w.seq = SEQ_END;
      end
      // SAK received: take SAK, start appending
      5'd10: begin
        w.act = ACT_SEL_INIT; w.seq = SEQ_NEXT;
      end
      5'd11: begin
        w.act = ACT_APPEND;
        w.seq = SEQ_BRANCH; w.cond = CND_APPEND_MORE; w.target = UA_APPEND;
      end
      5'd12: begin
        w.act = ACT_IDX_CLR;
        w.seq = SEQ_BRANCH; w.cond = CND_NEXT_LEVEL; w.target = UA_NEXT_LEVEL;
      end
      // UID byte dump, one a step
      5'd13: begin
        w.emit = 1'b1; w.kind = KIND_UID; w.act = ACT_IDX_INC;
        w.seq = SEQ_BRANCH; w.cond = CND_UID_MORE; w.target = UA_UID_EMIT;
      end
      5'd14: begin
        w.emit = 1'b1; w.kind = KIND_FIN; w.st = ST_OK;
        w.ph_we = 1'b1; w.ph = PH_IDLE; w.seq = SEQ_END;
      end
      // next cascade level
      5'd15: begin
        w.act = ACT_NEXT_LEVEL; w.seq = SEQ_JUMP; w.target = UA_SEND_ANTI;
      end
      // SELECT unanswered or answered with an empty frame
      5'd16: begin
        w.emit = 1'b1; w.kind = KIND_FIN; w.st = ST_PROTOCOL;
        w.ph_we = 1'b1; w.ph = PH_IDLE; w.seq = SEQ_END;
      end
      default: begin
        w.seq = SEQ_END;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nfc_type_a_select_sequencer.sv =====
// ----------------------------------------------------------------------------
// nfc_type_a_select_sequencer
// Reader-side type A activation: REQA/WUPA, cascaded anticollision and SELECT.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o, in_word_i) takes one event word:
//    start, frame received or no response. Output channel (out_valid_o/
//    out_ready_i, out_word_o) gives transmit, wait, UID byte and finish words;
//    the final word caused by an event has last set.
//  - An event is taken at the in_valid_i/in_ready_o handshake and then run by a
//    microcode sequencer, one control word per cycle unless a stalled receiver
//    holds the step counter.
//  - A SAK that opens the next level runs the append loop and the level check
//    before its anticollision word; the final SAK runs the append loop, the
//    level check, up to twelve UID bytes and the finish.
//  - A new event is taken once the last word of the previous one has been
//    loaded into the output register, so it may wait there meanwhile.
//  - A stalled receiver holds the step counter on any step that emits.
//  - Events that mean nothing in the current phase are taken and give no word.
//  - Reset returns the sequencer to idle, clears the run state and loads the
//    configuration defaults. Configuration writes go straight to registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_type_a_select_sequencer #(
  parameter int unsigned MAX_LEVELS = 3
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [2:0]             cfg_idx_i,
  input  wire  [7:0]             cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  nfcsel_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output nfcsel_pkg::out_word_t  out_word_o
);
  import nfcsel_pkg::*;

  // configuration
  logic [2:0] cfg_attempts_q;
  logic [7:0] cfg_retry_q, cfg_react_q, cfg_atqa_q, cfg_anti_q, cfg_sel_q;

  // sequencer
  logic   busy_q, busy_d;
  upc_t   upc_q, upc_d;
  ucode_t uw;

  // datapath
  logic [39:0] rx_q, rx_d;
  phase_e      phase_q, phase_d;
  logic [1:0]  level_q, level_d;
  logic [2:0]  attempt_q, attempt_d;
  logic [15:0] atqa_q, atqa_d;
  logic [39:0] part_q, part_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  sak_q, sak_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  uid_q [UidDepth];
  logic        uid_we;

  // output register
  out_word_t out_q, ow;
  logic      out_valid_q;

  logic      out_free, step, in_acc, disp_go, cond_ok;
  upc_t      disp_addr;
  logic [7:0] sel_code, time_v;

  assign uw       = ucode_rom(upc_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = busy_q && (!uw.emit || out_free);
  assign in_ready_o = !busy_q;
  assign in_acc   = in_valid_i && !busy_q;
  assign sel_code = SelCodeBase + {5'd0, level_q, 1'b0};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_attempts_q <= 3'd3;
      cfg_retry_q    <= 8'd5;
      cfg_react_q    <= 8'd5;
      cfg_atqa_q     <= 8'd10;
      cfg_anti_q     <= 8'd20;
      cfg_sel_q      <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ANTICOLL_ATTEMPTS:   cfg_attempts_q <= cfg_data_i[2:0];
        CFG_RETRY_DELAY_MS:      cfg_retry_q    <= cfg_data_i;
        CFG_REACTIVATE_DELAY_MS: cfg_react_q    <= cfg_data_i;
        CFG_ATQA_TIMEOUT_MS:     cfg_atqa_q     <= cfg_data_i;
        CFG_ANTICOLL_TIMEOUT_MS: cfg_anti_q     <= cfg_data_i;
        CFG_SELECT_TIMEOUT_MS:   cfg_sel_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dispatch: pick the program entry for an event
  always_comb begin
    disp_go   = 1'b0;
    disp_addr = UA_START;
    priority if (mode_e'(in_word_i.mode) == MODE_START) begin
      disp_go = 1'b1;
    end else if (mode_e'(in_word_i.mode) == MODE_FRAME ||
                 mode_e'(in_word_i.mode) == MODE_TIMEOUT) begin
      unique case (phase_q)
        PH_REQA, PH_WUPA: begin
          disp_go = 1'b1;
          if (mode_e'(in_word_i.mode) == MODE_FRAME && in_word_i.rx_len >= 3'd2)
            disp_addr = UA_ATQA_OK;
          else if (phase_q == PH_REQA)
            disp_addr = UA_REQA_FAIL;
          else
            disp_addr = UA_FIN_NOCARD;
        end
        PH_ANTI: begin
          disp_go = 1'b1;
          if (mode_e'(in_word_i.mode) == MODE_FRAME && in_word_i.rx_len == 3'd5)
            disp_addr = UA_ANTI_OK;
          else
            disp_addr = UA_ANTI_FAIL;
        end
        PH_SEL: begin
          disp_go = 1'b1;
          if (mode_e'(in_word_i.mode) == MODE_FRAME && in_word_i.rx_len >= 3'd1)
            disp_addr = UA_SEL_OK;
          else
            disp_addr = UA_FIN_PROTO;
        end
        default: ;
      endcase
    end else begin
      disp_go = 1'b0;
    end
  end

  // branch conditions
  always_comb begin
    unique case (uw.cond)
      CND_RETRY_MORE:  cond_ok = !(attempt_q >= cfg_attempts_q || attempt_q == 3'd0);
      CND_APPEND_MORE: cond_ok = idx_q < 4'd3;
      CND_NEXT_LEVEL:  cond_ok = sak_q[SakCascadeBit] &&
                                 ((32'(level_q) + 32'd1) < MAX_LEVELS);
      CND_UID_MORE:    cond_ok = ({1'b0, idx_q} + 5'd1) < {1'b0, cnt_q};
      default:         cond_ok = 1'b0;
    endcase
  end

  // step counter and datapath next state
  always_comb begin
    busy_d    = busy_q;
    upc_d     = upc_q;
    rx_d      = rx_q;
    phase_d   = phase_q;
    level_d   = level_q;
    attempt_d = attempt_q;
    atqa_d    = atqa_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    sak_d     = sak_q;
    idx_d     = idx_q;
    uid_we    = 1'b0;

    if (in_acc && disp_go) begin
      busy_d = 1'b1;
      upc_d  = disp_addr;
      rx_d   = in_word_i.rx_data;
    end

    if (step) begin
      unique case (uw.seq)
        SEQ_NEXT:   upc_d = upc_q + 5'd1;
        SEQ_JUMP:   upc_d = uw.target;
        SEQ_BRANCH: upc_d = cond_ok ? uw.target : upc_q + 5'd1;
        SEQ_END:    busy_d = 1'b0;
        default:    busy_d = 1'b0;
      endcase

      if (uw.ph_we) phase_d = uw.ph;

      unique case (uw.act)
        ACT_START: begin
          level_d = 2'd0; attempt_d = 3'd0; cnt_d = 4'd0;
          atqa_d = 16'd0; sak_d = 8'd0; part_d = 40'd0;
        end
        ACT_ATQA: begin
          atqa_d = rx_q[15:0]; level_d = 2'd0; attempt_d = 3'd0; cnt_d = 4'd0;
        end
        ACT_UID_PART:    part_d = rx_q;
        ACT_INC_ATTEMPT: attempt_d = attempt_q + 3'd1;
        ACT_SEL_INIT: begin
          sak_d = rx_q[7:0];
          idx_d = (part_q[7:0] == CascadeTag) ? 4'd1 : 4'd0;
        end
        ACT_APPEND: begin
          // store is full at twelve bytes; further bytes are dropped
          if (cnt_q < UidMaxBytes) begin
            uid_we = 1'b1;
            cnt_d  = cnt_q + 4'd1;
          end
          idx_d = idx_q + 4'd1;
        end
        ACT_IDX_CLR:    idx_d = 4'd0;
        ACT_IDX_INC:    idx_d = idx_q + 4'd1;
        ACT_NEXT_LEVEL: begin
          level_d = level_q + 2'd1; attempt_d = 3'd0;
        end
        default: ;
      endcase
    end
  end

  // time field source
  always_comb begin
    unique case (uw.tsel)
      TS_ATQA:     time_v = cfg_atqa_q;
      TS_ANTICOLL: time_v = cfg_anti_q;
      TS_SELECT:   time_v = cfg_sel_q;
      TS_RETRY:    time_v = cfg_retry_q;
      TS_REACT:    time_v = cfg_react_q;
      default:     time_v = 8'd0;
    endcase
  end

  // output word assembly; fields that do not apply stay zero
  always_comb begin
    ow      = '0;
    ow.kind = uw.kind;
    ow.last = (uw.seq == SEQ_END);
    unique case (uw.kind)
      KIND_TX: begin
        ow.tx_command      = uw.cmd;
        ow.select_code     = uw.code_en ? sel_code : 8'd0;
        ow.tx_payload      = uw.payload_en ? rx_q : 40'd0;
        ow.anticoll_enable = uw.ac;
        ow.time_ms         = time_v;
      end
      KIND_WAIT: ow.time_ms  = time_v;
      KIND_UID:  ow.uid_byte = uid_q[idx_q];
      KIND_FIN: begin
        ow.status     = uw.st;
        ow.atqa       = atqa_q;
        ow.sak        = sak_q;
        ow.uid_length = cnt_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UA_START;
      phase_q     <= PH_IDLE;
      level_q     <= 2'd0;
      attempt_q   <= 3'd0;
      atqa_q      <= 16'd0;
      part_q      <= 40'd0;
      cnt_q       <= 4'd0;
      sak_q       <= 8'd0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      upc_q     <= upc_d;
      phase_q   <= phase_d;
      level_q   <= level_d;
      attempt_q <= attempt_d;
      atqa_q    <= atqa_d;
      part_q    <= part_d;
      cnt_q     <= cnt_d;
      sak_q     <= sak_d;
      idx_q     <= idx_d;
      if (step && uw.emit)
        out_valid_q <= 1'b1;
      else if (out_ready_i)
        out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;
    if (step && uw.emit) out_q <= ow;
    if (uid_we) uid_q[cnt_q] <= part_q[{idx_q[1:0], 3'b000} +: 8];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  a_uid_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= UidMaxBytes)
    else $error("uid count beyond store depth");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && uw.emit && uw.seq == SEQ_END) |=> !busy_q)
    else $error("sequencer still busy after last word");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && uw.emit && uw.kind == KIND_FIN) |=> (phase_q == PH_IDLE))
    else $error("phase not idle after finish");

  a_uid_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && uw.emit && uw.kind == KIND_UID) |-> (idx_q < cnt_q))
    else $error("UID byte read beyond assembled count");

endmodule

`default_nettype wire

// ===== tb/sv/nfc_type_a_select_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// nfc_type_a_select_sequencer_test
// Self-checking bench for the type A activation sequencer. Directed event runs
// cover idle events, the WUPA fallback, collision give-up, a full three-level
// cascade, restart and an empty SELECT answer. Randomised card sessions then run
// under several register settings and flow-control mixes. Every output word
// is checked field by field against an in-bench protocol model.
// ----------------------------------------------------------------------------
module nfc_type_a_select_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nfcsel_pkg::*;

  localparam int unsigned CascadeLevels = 3;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned CycleLimit    = 600000;

  // Bench signals; those the bench drives are known from time zero
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_reg_e   cfg_idx   = CFG_ANTICOLL_ATTEMPTS;
  logic [7:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  out_word_t  result_word;

  // Flow control knobs, percent per cycle
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  bit          input_busy         = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Words the model says are still to come, oldest first
  out_word_t   expected_words[$];
  int unsigned new_words;

  // Model copy of the registers (reset values)
  logic [2:0] max_tries     = 3'd3;
  logic [7:0] retry_ms      = 8'd5;
  logic [7:0] reactivate_ms = 8'd5;
  logic [7:0] atqa_to_ms    = 8'd10;
  logic [7:0] anti_to_ms    = 8'd20;
  logic [7:0] sel_to_ms     = 8'd10;

  // Model copy of the run state
  phase_e      card_phase    = PH_IDLE;
  logic [1:0]  cascade_level = '0;
  logic [2:0]  failed_tries  = '0;
  logic [15:0] atqa_seen     = '0;
  logic [39:0] uid_part      = '0;
  logic [7:0]  uid_bytes [12];
  logic [3:0]  uid_len       = '0;
  logic [7:0]  sak_seen      = '0;

  nfc_type_a_select_sequencer #(
    .MAX_LEVELS(CascadeLevels)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (result_word)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Protocol model
  // ---------------------------------------------------------------------------
  function automatic void add_word(out_word_t o);
    expected_words.push_back(o);
    new_words++;
  endfunction

  function automatic void add_transmit(tx_cmd_e cmd, logic [7:0] code, logic [39:0] payload,
                                       logic ac, logic [7:0] t);
    out_word_t o;
    o = '0;
    o.kind            = KIND_TX;
    o.tx_command      = cmd;
    o.select_code     = code;
    o.tx_payload      = payload;
    o.anticoll_enable = ac;
    o.time_ms         = t;
    add_word(o);
  endfunction

  function automatic void add_wait(logic [7:0] t);
    out_word_t o;
    o = '0;
    o.kind    = KIND_WAIT;
    o.time_ms = t;
    add_word(o);
  endfunction

  function automatic void add_finish(status_e st);
    out_word_t o;
    o = '0;
    o.kind       = KIND_FIN;
    o.status     = st;
    o.atqa       = atqa_seen;
    o.sak        = sak_seen;
    o.uid_length = uid_len;
    add_word(o);
    card_phase = PH_IDLE;
  endfunction

  // 0x93 / 0x95 / 0x97 by cascade level
  function automatic logic [7:0] level_code();
    return SelCodeBase + {5'd0, cascade_level, 1'b0};
  endfunction

  function automatic void send_anticoll();
    add_transmit(TX_ANTICOLL, level_code(), 40'd0, 1'b1, anti_to_ms);
    card_phase = PH_ANTI;
  endfunction

  // Works out the words one accepted event causes; count left in new_words
  function automatic void predict_event(in_word_t w);
    logic      answered;
    int        first;
    out_word_t o;
    new_words = 0;
    answered  = (w.mode == MODE_FRAME);
    if (w.mode == MODE_START) begin
      cascade_level = '0;
      failed_tries  = '0;
      uid_len       = '0;
      atqa_seen     = '0;
      sak_seen      = '0;
      uid_part      = '0;
      add_transmit(TX_REQA, 8'd0, 40'd0, 1'b0, atqa_to_ms);
      card_phase = PH_REQA;
    end else if (w.mode == MODE_FRAME || w.mode == MODE_TIMEOUT) begin
      case (card_phase)
        PH_REQA, PH_WUPA: begin
          // two or more bytes make an ATQA, anything shorter is silence
          if (answered && w.rx_len >= 3'd2) begin
            atqa_seen     = w.rx_data[15:0];
            cascade_level = '0;
            failed_tries  = '0;
            uid_len       = '0;
            send_anticoll();
          end else if (card_phase == PH_REQA) begin
            add_wait(reactivate_ms);
            add_transmit(TX_WUPA, 8'd0, 40'd0, 1'b0, atqa_to_ms);
            card_phase = PH_WUPA;
          end else begin
            add_finish(ST_NO_CARD);
          end
        end
        PH_ANTI: begin
          if (answered && w.rx_len == 3'd5) begin
            uid_part = w.rx_data;
            add_transmit(TX_SELECT, level_code(), w.rx_data, 1'b0, sel_to_ms);
            card_phase = PH_SEL;
          end else begin
            // the retry wait goes out even on the last try
            add_wait(retry_ms);
            failed_tries = failed_tries + 3'd1;
            if (failed_tries >= max_tries || failed_tries == 3'd0) add_finish(ST_COLLISION);
            else send_anticoll();
          end
        end
        PH_SEL: begin
          if (answered && w.rx_len >= 3'd1) begin
            first = (uid_part[7:0] == CascadeTag) ? 1 : 0;
            for (int i = first; i < 4; i++) begin
              if (uid_len < UidMaxBytes) begin
                uid_bytes[uid_len] = uid_part[8*i +: 8];
                uid_len = uid_len + 4'd1;
              end
            end
            sak_seen = w.rx_data[7:0];
            if (sak_seen[SakCascadeBit] && int'(cascade_level) + 1 < CascadeLevels) begin
              cascade_level = cascade_level + 2'd1;
              failed_tries  = '0;
              send_anticoll();
            end else begin
              for (int i = 0; i < int'(uid_len); i++) begin
                o = '0;
                o.kind     = KIND_UID;
                o.uid_byte = uid_bytes[i];
                add_word(o);
              end
              add_finish(ST_OK);
            end
          end else begin
            add_finish(ST_PROTOCOL);
          end
        end
        default: ;
      endcase
    end
    if (new_words != 0) begin
      o = expected_words.pop_back();
      o.last = 1'b1;
      expected_words.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic in_word_t rf_word(mode_e m, logic [2:0] len, logic [39:0] data);
    in_word_t w;
    w.mode    = m;
    w.rx_len  = len;
    w.rx_data = data;
    return w;
  endfunction

  task automatic idle_input();
    if (input_busy) begin
      in_valid <= 1'b0;
      input_busy = 1'b0;
    end
  endtask

  // Offer one word, wait for the handshake, then run the model on it
  task automatic send_event(input in_word_t w);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      idle_input();
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    input_busy = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_event(w);
  endtask

  // Hold off until every expected word is in; optionally let the block settle
  task automatic drain_results(input bit settle);
    idle_input();
    do @(posedge clk); while (expected_words.size() != 0);
    if (settle) repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Writes all six registers with the block quiet
  task automatic load_config(input logic [2:0] tries, input logic [7:0] retry,
                             input logic [7:0] react, input logic [7:0] atqa_to,
                             input logic [7:0] anti_to, input logic [7:0] sel_to);
    drain_results(1'b1);
    max_tries     = tries;
    retry_ms      = retry;
    reactivate_ms = react;
    atqa_to_ms    = atqa_to;
    anti_to_ms    = anti_to;
    sel_to_ms     = sel_to;
    write_reg(CFG_ANTICOLL_ATTEMPTS, {5'd0, tries});
    write_reg(CFG_RETRY_DELAY_MS, retry);
    write_reg(CFG_REACTIVATE_DELAY_MS, react);
    write_reg(CFG_ATQA_TIMEOUT_MS, atqa_to);
    write_reg(CFG_ANTICOLL_TIMEOUT_MS, anti_to);
    write_reg(CFG_SELECT_TIMEOUT_MS, sel_to);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: word with none expected, expected none actual %h", $time, result_word);
      end else begin
        want = expected_words.pop_front();
        check_field("kind", 40'(want.kind), 40'(result_word.kind));
        check_field("tx_command", 40'(want.tx_command), 40'(result_word.tx_command));
        check_field("select_code", 40'(want.select_code), 40'(result_word.select_code));
        check_field("tx_payload", want.tx_payload, result_word.tx_payload);
        check_field("anticoll_enable", 40'(want.anticoll_enable),
                    40'(result_word.anticoll_enable));
        check_field("time_ms", 40'(want.time_ms), 40'(result_word.time_ms));
        check_field("uid_byte", 40'(want.uid_byte), 40'(result_word.uid_byte));
        check_field("status", 40'(want.status), 40'(result_word.status));
        check_field("atqa", 40'(want.atqa), 40'(result_word.atqa));
        check_field("sak", 40'(want.sak), 40'(result_word.sak));
        check_field("uid_length", 40'(want.uid_length), 40'(result_word.uid_length));
        check_field("last", 40'(want.last), 40'(result_word.last));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: cycle limit reached, %0d words outstanding", $time,
               expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frame and timeout events with no run going, and the unused mode code
  task automatic test_idle_events();
    send_event(rf_word(MODE_FRAME, 3'd7, '1));
    send_event(rf_word(MODE_TIMEOUT, 3'd0, '0));
    send_event(rf_word(MODE_UNUSED, 3'd7, '1));
  endtask

  // REQA silent, WUPA answered by a one-byte frame: no card
  task automatic test_no_card();
    send_event(rf_word(MODE_START, 3'd0, '0));
    send_event(rf_word(MODE_TIMEOUT, 3'd3, 40'h12_3456_789a));
    send_event(rf_word(MODE_FRAME, 3'd1, 40'h00_0000_0044));
  endtask

  // Three failed tries at the default setting end in a collision finish
  task automatic test_collision_limit();
    send_event(rf_word(MODE_START, 3'd0, '0));
    send_event(rf_word(MODE_FRAME, 3'd2, 40'hff_ffff_0004));
    send_event(rf_word(MODE_FRAME, 3'd4, 40'h01_0203_0405));
    send_event(rf_word(MODE_TIMEOUT, 3'd5, '1));
    send_event(rf_word(MODE_FRAME, 3'd6, 40'ha5_a5a5_a5a5));
  endtask

  // WUPA path, cascade tag on level 1, then two more levels; last SAK still
  // asks for another level but the level limit ends the run
  task automatic test_full_cascade();
    send_event(rf_word(MODE_START, 3'd0, '0));
    send_event(rf_word(MODE_TIMEOUT, 3'd0, '0));
    send_event(rf_word(MODE_FRAME, 3'd7, '1));
    send_event(rf_word(MODE_UNUSED, 3'd0, '0));
    send_event(rf_word(MODE_FRAME, 3'd5, {32'hbb11_2233, CascadeTag}));
    send_event(rf_word(MODE_FRAME, 3'd1, 40'h00_0000_0004));
    send_event(rf_word(MODE_FRAME, 3'd5, 40'hcc_4455_6677));
    send_event(rf_word(MODE_FRAME, 3'd3, 40'h00_00ff_ff24));
    send_event(rf_word(MODE_FRAME, 3'd5, 40'h00_0000_0000));
    send_event(rf_word(MODE_FRAME, 3'd7, '1));
  endtask

  // Start mid-run clears everything; an empty SELECT answer is a protocol error
  task automatic test_restart_and_protocol_error();
    send_event(rf_word(MODE_START, 3'd0, '0));
    send_event(rf_word(MODE_FRAME, 3'd2, 40'h00_0000_4400));
    send_event(rf_word(MODE_START, 3'd7, '1));
    send_event(rf_word(MODE_FRAME, 3'd3, 40'h00_0000_0344));
    send_event(rf_word(MODE_FRAME, 3'd5, 40'h9f_8e7d_6c5b));
    send_event(rf_word(MODE_FRAME, 3'd0, '1));
  endtask

  // Next event of a plausible session from the current phase, with some noise
  function automatic in_word_t next_event();
    in_word_t    w;
    logic [63:0] noise;
    int unsigned roll;
    noise     = {$urandom, $urandom};
    roll      = $urandom_range(99);
    w.mode    = MODE_FRAME;
    w.rx_len  = 3'($urandom_range(7));
    w.rx_data = noise[39:0];
    if (roll < 6) begin
      w.mode = 2'($urandom_range(3));
      return w;
    end
    case (card_phase)
      PH_REQA, PH_WUPA: begin
        if (roll < 70) w.rx_len = 3'($urandom_range(7, 2));
        else if (roll < 85) w.mode = MODE_TIMEOUT;
        else w.rx_len = 3'($urandom_range(1));
      end
      PH_ANTI: begin
        if (roll < 65) begin
          w.rx_len = 3'd5;
          if ($urandom_range(99) < 35) w.rx_data[7:0] = CascadeTag;
        end else if (roll < 82) begin
          w.mode = MODE_TIMEOUT;
        end else begin
          // any length but five
          w.rx_len = 3'($urandom_range(5));
          if (w.rx_len == 3'd5) w.rx_len = 3'($urandom_range(7, 6));
        end
      end
      PH_SEL: begin
        if (roll < 88) begin
          w.rx_len = 3'($urandom_range(7, 1));
          w.rx_data[SakCascadeBit] = ($urandom_range(99) < 55);
        end else if (roll < 94) begin
          w.mode = MODE_TIMEOUT;
        end else begin
          w.rx_len = 3'd0;
        end
      end
      default: w.mode = MODE_START;
    endcase
    return w;
  endfunction

  // Random sessions until target events have produced words
  task automatic test_random_traffic(input int unsigned target, input int unsigned send_pct,
                                     input int unsigned stall_pct);
    int unsigned done;
    done = 0;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
    while (done < target) begin
      send_event(next_event());
      if (new_words != 0) done++;
      if ($urandom_range(99) < 2) drain_results(1'b0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_events();
    test_no_card();
    test_collision_limit();
    test_full_cascade();
    test_restart_and_protocol_error();

    // minimum setting: zero tries acts as one, zero delays and timeouts
    load_config(3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    test_random_traffic(65, 0, 0);

    load_config(3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    test_random_traffic(65, 60, 0);

    load_config(3'($urandom_range(7, 1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(65, 0, 60);

    load_config(3'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(65, 26, 26);

    load_config(3'($urandom_range(7, 2)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(65, 0, 0);

    drain_results(1'b1);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nfcsel_pkg.sv
hw/rtl/nfc_type_a_select_sequencer.sv
tb/sv/nfc_type_a_select_sequencer_test.sv
